@@ rtl/frr_pkg.sv @@
// ----------------------------------------------------------------------------
// frr_pkg
// Types, character constants and code helpers for the FTP reply recognizer.
// ----------------------------------------------------------------------------
package frr_pkg;

   // Received byte classes
   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_SPACE,
      CLS_MINUS,
      CLS_CR,
      CLS_LF,
      CLS_OTHER
   } byte_class_type;

   localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;

   // Recognizer state, one-hot. The first tail digit is consumed from the
   // line prefix state, so it has no state of its own.
   typedef enum logic [13:0] {
      PH_HEAD1       = 14'b00_0000_0000_0001,
      PH_HEAD2       = 14'b00_0000_0000_0010,
      PH_HEAD3       = 14'b00_0000_0000_0100,
      PH_HEAD_SEP    = 14'b00_0000_0000_1000,
      PH_LINE_CR     = 14'b00_0000_0001_0000,
      PH_LINE_LF     = 14'b00_0000_0010_0000,
      PH_LINE_PREFIX = 14'b00_0000_0100_0000,
      PH_TAIL2       = 14'b00_0000_1000_0000,
      PH_TAIL3       = 14'b00_0001_0000_0000,
      PH_TAIL_SPACE  = 14'b00_0010_0000_0000,
      PH_END_CR      = 14'b00_0100_0000_0000,
      PH_END_LF      = 14'b00_1000_0000_0000,
      PH_ERROR       = 14'b01_0000_0000_0000,
      PH_DONE        = 14'b10_0000_0000_0000
   } phase_type;

   localparam int unsigned STATUS_W = 2;
   localparam int unsigned PHASE_W  = 4;

   localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

   localparam logic [PHASE_W-1:0] CODE_HEAD1       = 4'd0;
   localparam logic [PHASE_W-1:0] CODE_HEAD2       = 4'd1;
   localparam logic [PHASE_W-1:0] CODE_HEAD3       = 4'd2;
   localparam logic [PHASE_W-1:0] CODE_HEAD_SEP    = 4'd3;
   localparam logic [PHASE_W-1:0] CODE_LINE_CR     = 4'd4;
   localparam logic [PHASE_W-1:0] CODE_LINE_LF     = 4'd5;
   localparam logic [PHASE_W-1:0] CODE_LINE_PREFIX = 4'd6;
   localparam logic [PHASE_W-1:0] CODE_TAIL2       = 4'd8;
   localparam logic [PHASE_W-1:0] CODE_TAIL3       = 4'd9;
   localparam logic [PHASE_W-1:0] CODE_TAIL_SPACE  = 4'd10;
   localparam logic [PHASE_W-1:0] CODE_END_CR      = 4'd11;
   localparam logic [PHASE_W-1:0] CODE_END_LF      = 4'd12;

   // Wait-state number reported with each result, with 7 unused; 0 once finished
   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] code;
      unique case (ph)
         PH_HEAD1:       code = CODE_HEAD1;
         PH_HEAD2:       code = CODE_HEAD2;
         PH_HEAD3:       code = CODE_HEAD3;
         PH_HEAD_SEP:    code = CODE_HEAD_SEP;
         PH_LINE_CR:     code = CODE_LINE_CR;
         PH_LINE_LF:     code = CODE_LINE_LF;
         PH_LINE_PREFIX: code = CODE_LINE_PREFIX;
         PH_TAIL2:       code = CODE_TAIL2;
         PH_TAIL3:       code = CODE_TAIL3;
         PH_TAIL_SPACE:  code = CODE_TAIL_SPACE;
         PH_END_CR:      code = CODE_END_CR;
         PH_END_LF:      code = CODE_END_LF;
         default:        code = CODE_HEAD1;
      endcase
      return code;
   endfunction

   function automatic logic [STATUS_W-1:0] phase_status(input phase_type ph);
      logic [STATUS_W-1:0] st;
      unique case (ph)
         PH_DONE:  st = STATUS_DONE;
         PH_ERROR: st = STATUS_ERROR;
         default:  st = STATUS_BUSY;
      endcase
      return st;
   endfunction

endpackage

@@ rtl/frr_if.sv @@
// ----------------------------------------------------------------------------
// frr_req_if / frr_rsp_if
// Valid/ready channels carrying received bytes in and reply status out.
// ----------------------------------------------------------------------------
interface frr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       restart;

   modport source (output valid, output rx_byte, output restart, input ready);
   modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface frr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [frr_pkg::STATUS_W-1:0]   status;
   logic [frr_pkg::PHASE_W-1:0]    parse_phase;

   modport source (output valid, output status, output parse_phase, input ready);
   modport sink   (input valid, input status, input parse_phase, output ready);
endinterface

@@ rtl/frr_classify.sv @@
// ----------------------------------------------------------------------------
// frr_classify
// Sorts a received byte into digit, space, minus, CR, LF or other.
// ----------------------------------------------------------------------------
module frr_classify (
   input  logic [7:0]              rx_byte,
   output frr_pkg::byte_class_type byte_class
);

   always_comb begin
      if (rx_byte >= frr_pkg::CHAR_DIGIT_LO && rx_byte <= frr_pkg::CHAR_DIGIT_HI) begin
         byte_class = frr_pkg::CLS_DIGIT;
      end else if (rx_byte == frr_pkg::CHAR_SPACE) begin
         byte_class = frr_pkg::CLS_SPACE;
      end else if (rx_byte == frr_pkg::CHAR_MINUS) begin
         byte_class = frr_pkg::CLS_MINUS;
      end else if (rx_byte == frr_pkg::CHAR_CR) begin
         byte_class = frr_pkg::CLS_CR;
      end else if (rx_byte == frr_pkg::CHAR_LF) begin
         byte_class = frr_pkg::CLS_LF;
      end else begin
         byte_class = frr_pkg::CLS_OTHER;
      end
   end

endmodule

@@ rtl/frr_advance.sv @@
// ----------------------------------------------------------------------------
// frr_advance
// Next-state logic of the reply framing recognizer.
// ----------------------------------------------------------------------------
module frr_advance (
   input  frr_pkg::phase_type      phase,
   input  logic                    restart,
   input  frr_pkg::byte_class_type byte_class,
   output frr_pkg::phase_type      next_phase
);

   frr_pkg::phase_type cur;

   // restart drops back to the first code digit before this byte is seen
   assign cur = restart ? frr_pkg::PH_HEAD1 : phase;

   always_comb begin
      unique case (cur)
         frr_pkg::PH_HEAD1:
            next_phase = (byte_class == frr_pkg::CLS_DIGIT) ? frr_pkg::PH_HEAD2
                                                           : frr_pkg::PH_ERROR;
         frr_pkg::PH_HEAD2:
            next_phase = (byte_class == frr_pkg::CLS_DIGIT) ? frr_pkg::PH_HEAD3
                                                           : frr_pkg::PH_ERROR;
         frr_pkg::PH_HEAD3:
            next_phase = (byte_class == frr_pkg::CLS_DIGIT) ? frr_pkg::PH_HEAD_SEP
                                                           : frr_pkg::PH_ERROR;
         frr_pkg::PH_HEAD_SEP: begin
            if (byte_class == frr_pkg::CLS_SPACE) begin
               next_phase = frr_pkg::PH_END_CR;
            end else if (byte_class == frr_pkg::CLS_MINUS) begin
               next_phase = frr_pkg::PH_LINE_CR;
            end else begin
               next_phase = frr_pkg::PH_ERROR;
            end
         end
         frr_pkg::PH_LINE_CR:
            next_phase = (byte_class == frr_pkg::CLS_CR) ? frr_pkg::PH_LINE_LF
                                                        : frr_pkg::PH_LINE_CR;
         frr_pkg::PH_LINE_LF:
            next_phase = (byte_class == frr_pkg::CLS_LF) ? frr_pkg::PH_LINE_PREFIX
                                                        : frr_pkg::PH_LINE_CR;
         frr_pkg::PH_LINE_PREFIX: begin
            // a digit opens the closing line; its code is not checked
            if (byte_class == frr_pkg::CLS_DIGIT) begin
               next_phase = frr_pkg::PH_TAIL2;
            end else if (byte_class == frr_pkg::CLS_SPACE) begin
               next_phase = frr_pkg::PH_LINE_CR;
            end else begin
               next_phase = frr_pkg::PH_ERROR;
            end
         end
         frr_pkg::PH_TAIL2:
            next_phase = (byte_class == frr_pkg::CLS_DIGIT) ? frr_pkg::PH_TAIL3
                                                           : frr_pkg::PH_ERROR;
         frr_pkg::PH_TAIL3:
            next_phase = (byte_class == frr_pkg::CLS_DIGIT) ? frr_pkg::PH_TAIL_SPACE
                                                           : frr_pkg::PH_ERROR;
         frr_pkg::PH_TAIL_SPACE:
            next_phase = (byte_class == frr_pkg::CLS_SPACE) ? frr_pkg::PH_END_CR
                                                           : frr_pkg::PH_ERROR;
         frr_pkg::PH_END_CR:
            next_phase = (byte_class == frr_pkg::CLS_CR) ? frr_pkg::PH_END_LF
                                                        : frr_pkg::PH_END_CR;
         frr_pkg::PH_END_LF:
            next_phase = (byte_class == frr_pkg::CLS_LF) ? frr_pkg::PH_DONE
                                                        : frr_pkg::PH_END_CR;
         frr_pkg::PH_ERROR: next_phase = frr_pkg::PH_ERROR;
         frr_pkg::PH_DONE:  next_phase = frr_pkg::PH_DONE;
         default:           next_phase = frr_pkg::PH_ERROR;
      endcase
   end

endmodule

@@ rtl/ftp_reply_frame_recognizer_top.sv @@
// ----------------------------------------------------------------------------
// ftp_reply_frame_recognizer_top
// Tracks the framing of one FTP control reply, one received byte per transfer.
// ----------------------------------------------------------------------------
// Takes one byte every clock cycle while the result side is not stalled and
// returns one status per byte. Each byte is held in an input register,
// classed and run through the one-hot phase register's next-state logic, and
// the status and wait-state number land in a result register; the phase
// register update per byte sets the one-byte-per-cycle rate. Completion and
// framing error stay reported until a byte arrives with restart set. Stalls
// on the result side hold both stages and back-pressure the input.
module ftp_reply_frame_recognizer_top (
   input  logic      clock,
   input  logic      reset,
   frr_req_if.sink   req_if,
   frr_rsp_if.source rsp_if
);

   logic                          in_valid_ff, in_valid_in;
   logic [7:0]                    rx_byte_ff, rx_byte_in;
   logic                          restart_ff, restart_in;
   frr_pkg::phase_type            phase_ff, phase_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [frr_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [frr_pkg::PHASE_W-1:0]   parse_phase_ff, parse_phase_in;

   logic                    advance;
   logic                    move;
   logic                    req_xfer;
   frr_pkg::byte_class_type byte_class;
   frr_pkg::phase_type      next_phase;

   frr_classify u_classify (
      .rx_byte    (rx_byte_ff),
      .byte_class (byte_class)
   );

   frr_advance u_advance (
      .phase      (phase_ff),
      .restart    (restart_ff),
      .byte_class (byte_class),
      .next_phase (next_phase)
   );

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign move         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_xfer     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in    = in_valid_ff;
      rx_byte_in     = rx_byte_ff;
      restart_in     = restart_ff;
      phase_in       = phase_ff;
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      parse_phase_in = parse_phase_ff;

      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
      if (req_xfer) begin
         rx_byte_in = req_if.rx_byte;
         restart_in = req_if.restart;
      end
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
      if (move) begin
         phase_in       = next_phase;
         status_in      = frr_pkg::phase_status(next_phase);
         parse_phase_in = frr_pkg::phase_code(next_phase);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= frr_pkg::PH_HEAD1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_byte_ff     <= rx_byte_in;
      restart_ff     <= restart_in;
      status_ff      <= status_in;
      parse_phase_ff <= parse_phase_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.parse_phase = parse_phase_ff;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for ftp_reply_frame_recognizer_top. A short directed table walks
// single-line, multi-line, sticky and error framings, then about 700 random
// bytes follow. Most of them form well-framed replies with random text, and
// the rest is corrupted replies and noise. Every status is checked against a
// byte-level predictor, under changing idle patterns on both channels and one
// long result-side hold-off.
// ----------------------------------------------------------------------------
module tb;
   import frr_pkg::*;

   localparam int N_RANDOM     = 700;
   localparam int MODE_SPAN    = 50;
   localparam int PRESSURE_AT  = 200;
   localparam int HOLD_CYCLES  = 64;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int MAX_PRINTS   = 20;

   typedef enum logic [3:0] {
      W_HEAD1, W_HEAD2, W_HEAD3, W_HEAD_SEP, W_LINE_CR, W_LINE_LF, W_LINE_PREFIX,
      W_TAIL1, W_TAIL2, W_TAIL3, W_TAIL_SPACE, W_END_CR, W_END_LF, W_ERROR, W_DONE
   } wait_state_type;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PHASE_W-1:0]  parse_phase;
   } reply_result_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       restart;
   } rx_item_type;

   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             restart;
      logic             typed;
      reply_result_type res;
   } dir_row_type;

   localparam reply_result_type NO_RES   = '{STATUS_BUSY, CODE_HEAD1};
   localparam reply_result_type RES_DONE = '{STATUS_DONE, CODE_HEAD1};
   localparam reply_result_type RES_ERR  = '{STATUS_ERROR, CODE_HEAD1};
   localparam int N_DIR = 26;

   // single-line, multi-line with CR inside LF wait, continuation line,
   // closing code differing from the opening one, sticky ends, restart
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{CHAR_DIGIT_LO, 1'b0, 1'b1, '{STATUS_BUSY, CODE_HEAD2}},
      '{CHAR_DIGIT_HI, 1'b0, 1'b0, NO_RES},
      '{CHAR_DIGIT_HI, 1'b0, 1'b0, NO_RES},
      '{CHAR_SPACE,    1'b0, 1'b0, NO_RES},
      '{CHAR_CR,       1'b0, 1'b0, NO_RES},
      '{CHAR_MINUS,    1'b0, 1'b0, NO_RES},
      '{CHAR_CR,       1'b0, 1'b0, NO_RES},
      '{CHAR_LF,       1'b0, 1'b1, RES_DONE},
      '{8'h00,         1'b0, 1'b1, RES_DONE},
      '{8'h31,         1'b1, 1'b1, '{STATUS_BUSY, CODE_HEAD2}},
      '{8'h32,         1'b0, 1'b0, NO_RES},
      '{8'h33,         1'b0, 1'b0, NO_RES},
      '{CHAR_MINUS,    1'b0, 1'b0, NO_RES},
      '{CHAR_CR,       1'b0, 1'b0, NO_RES},
      '{CHAR_CR,       1'b0, 1'b0, NO_RES},
      '{CHAR_CR,       1'b0, 1'b0, NO_RES},
      '{CHAR_LF,       1'b0, 1'b0, NO_RES},
      '{CHAR_SPACE,    1'b0, 1'b0, NO_RES},
      '{8'h80,         1'b0, 1'b0, NO_RES},
      '{CHAR_CR,       1'b0, 1'b0, NO_RES},
      '{CHAR_LF,       1'b0, 1'b0, NO_RES},
      '{8'h37,         1'b0, 1'b0, NO_RES},
      '{8'h38,         1'b0, 1'b0, NO_RES},
      '{8'h39,         1'b0, 1'b1, '{STATUS_BUSY, CODE_TAIL_SPACE}},
      '{8'hFF,         1'b1, 1'b1, RES_ERR},
      '{CHAR_MINUS,    1'b0, 1'b1, RES_ERR}
   };

   logic clock = 1'b0;
   logic reset;

   frr_req_if req_ch ();
   frr_rsp_if rsp_ch ();

   ftp_reply_frame_recognizer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wait_state_type   reply_state = W_HEAD1;
   reply_result_type expected_status_q [$];
   rx_item_type      pending_bytes [$];
   idle_mode_type    idle_mode = IDLE_NONE;

   int items_sent     = 0;
   int results_seen   = 0;
   int done_results   = 0;
   int error_results  = 0;
   int mismatches     = 0;
   int stall_cycles   = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   bit pressure_done  = 1'b0;

   function automatic byte_class_type class_of(input logic [7:0] b);
      if (b >= CHAR_DIGIT_LO && b <= CHAR_DIGIT_HI) return CLS_DIGIT;
      if (b == CHAR_SPACE) return CLS_SPACE;
      if (b == CHAR_MINUS) return CLS_MINUS;
      if (b == CHAR_CR)    return CLS_CR;
      if (b == CHAR_LF)    return CLS_LF;
      return CLS_OTHER;
   endfunction

   function automatic wait_state_type next_wait(input wait_state_type cur,
                                                input byte_class_type cls);
      case (cur)
         W_HEAD1:       return cls == CLS_DIGIT ? W_HEAD2 : W_ERROR;
         W_HEAD2:       return cls == CLS_DIGIT ? W_HEAD3 : W_ERROR;
         W_HEAD3:       return cls == CLS_DIGIT ? W_HEAD_SEP : W_ERROR;
         W_HEAD_SEP: begin
            if (cls == CLS_SPACE) return W_END_CR;
            if (cls == CLS_MINUS) return W_LINE_CR;
            return W_ERROR;
         end
         W_LINE_CR:     return cls == CLS_CR ? W_LINE_LF : W_LINE_CR;
         W_LINE_LF:     return cls == CLS_LF ? W_LINE_PREFIX : W_LINE_CR;
         W_LINE_PREFIX: begin
            // a digit here is the first digit of the closing line
            if (cls == CLS_DIGIT) return W_TAIL2;
            if (cls == CLS_SPACE) return W_LINE_CR;
            return W_ERROR;
         end
         W_TAIL2:       return cls == CLS_DIGIT ? W_TAIL3 : W_ERROR;
         W_TAIL3:       return cls == CLS_DIGIT ? W_TAIL_SPACE : W_ERROR;
         W_TAIL_SPACE:  return cls == CLS_SPACE ? W_END_CR : W_ERROR;
         W_END_CR:      return cls == CLS_CR ? W_END_LF : W_END_CR;
         W_END_LF:      return cls == CLS_LF ? W_DONE : W_END_CR;
         W_ERROR:       return W_ERROR;
         W_DONE:        return W_DONE;
         default:       return W_ERROR;
      endcase
   endfunction

   // advances the tracked reply state by one byte and returns its status
   function automatic reply_result_type track_reply_byte(input logic [7:0] b,
                                                         input logic rs);
      reply_result_type r;
      if (rs) reply_state = W_HEAD1;
      reply_state = next_wait(reply_state, class_of(b));
      if (reply_state == W_DONE)
         r = RES_DONE;
      else if (reply_state == W_ERROR)
         r = RES_ERR;
      else
         r = '{STATUS_BUSY, PHASE_W'(reply_state)};
      return r;
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(0, 99) < 55;
         IDLE_BOTH: return $urandom_range(0, 99) < 26;
         default:   return 1'b0;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic rs, input logic typed,
                            input reply_result_type typed_res);
      reply_result_type predicted;
      while (sender_idles()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      req_ch.restart <= rs;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      predicted = track_reply_byte(b, rs);
      expected_status_q.push_back(typed ? typed_res : predicted);
   endtask

   function automatic logic [7:0] random_digit();
      return CHAR_DIGIT_LO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_CR) b = 8'h41;
      return b;
   endfunction

   // line body then CR LF; now and then a stray CR followed by plain text
   task automatic queue_line_text();
      int len;
      len = $urandom_range(0, 5);
      repeat (len) pending_bytes.push_back('{random_text_byte(), 1'b0});
      if ($urandom_range(0, 7) == 0) begin
         pending_bytes.push_back('{CHAR_CR, 1'b0});
         pending_bytes.push_back('{8'h78, 1'b0});
      end
      pending_bytes.push_back('{CHAR_CR, 1'b0});
      pending_bytes.push_back('{CHAR_LF, 1'b0});
   endtask

   task automatic queue_reply();
      int first;
      int n_cont;
      int pos;
      first = pending_bytes.size();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6))
            pending_bytes.push_back('{8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0});
         return;
      end
      pending_bytes.push_back('{random_digit(), $urandom_range(0, 9) != 0});
      pending_bytes.push_back('{random_digit(), 1'b0});
      pending_bytes.push_back('{random_digit(), 1'b0});
      if ($urandom_range(0, 1)) begin
         pending_bytes.push_back('{CHAR_SPACE, 1'b0});
         queue_line_text();
      end else begin
         pending_bytes.push_back('{CHAR_MINUS, 1'b0});
         queue_line_text();
         n_cont = $urandom_range(0, 3);
         repeat (n_cont) begin
            pending_bytes.push_back('{CHAR_SPACE, 1'b0});
            queue_line_text();
         end
         repeat (3) pending_bytes.push_back('{random_digit(), 1'b0});
         pending_bytes.push_back('{CHAR_SPACE, 1'b0});
         queue_line_text();
      end
      // bytes after the end must not move a finished reply
      repeat ($urandom_range(0, 2))
         pending_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0});
      if ($urandom_range(0, 5) == 0) begin
         pos = $urandom_range(first, pending_bytes.size() - 1);
         pending_bytes[pos].rx_byte = 8'($urandom_range(0, 255));
      end
   endtask

   task automatic report_mismatch(input string field, input int idx, input int got,
                                  input int want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch: result %0d %s got %0d expected %0d", idx, field, got, want);
   endtask

   // result checking
   always @(posedge clock) begin
      reply_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_status_q.size() == 0) begin
            report_mismatch("unexpected transfer, status", results_seen,
                            rsp_ch.status, -1);
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", results_seen, rsp_ch.status, want.status);
            if (rsp_ch.parse_phase !== want.parse_phase)
               report_mismatch("parse_phase", results_seen, rsp_ch.parse_phase,
                               want.parse_phase);
         end
         if (rsp_ch.status == STATUS_DONE)  done_results++;
         if (rsp_ch.status == STATUS_ERROR) error_results++;
         results_seen++;
      end
   end

   // result side ready, including one long hold-off while bytes keep coming
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!pressure_done && items_sent >= N_DIR + PRESSURE_AT) begin
         rsp_ch.ready  <= 1'b0;
         hold_left     <= HOLD_CYCLES - 1;
         pressure_done <= 1'b1;
      end else begin
         case (idle_mode)
            IDLE_RECV: rsp_ch.ready <= $urandom_range(0, 99) >= 55;
            IDLE_BOTH: rsp_ch.ready <= $urandom_range(0, 99) >= 26;
            default:   rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_ch.valid && !req_ch.ready) stall_cycles <= stall_cycles + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_status_q.size());
         $display("ftp_reply_frame_recognizer_top verification failed");
         $finish;
      end
   end

   initial begin
      rx_item_type nb;
      int random_sent;
      random_sent    = 0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      req_ch.restart = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIR; i++)
         send_byte(DIR_ROWS[i].rx_byte, DIR_ROWS[i].restart, DIR_ROWS[i].typed,
                   DIR_ROWS[i].res);

      while (random_sent < N_RANDOM) begin
         if (pending_bytes.size() == 0) queue_reply();
         idle_mode = idle_mode_type'((random_sent / MODE_SPAN) % 4);
         nb = pending_bytes.pop_front();
         send_byte(nb.rx_byte, nb.restart, 1'b0, NO_RES);
         random_sent++;
      end
      req_ch.valid <= 1'b0;

      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d bytes transferred (%0d from the directed table), %0d statuses checked",
               items_sent, N_DIR, results_seen);
      $display("%0d complete and %0d framing-error statuses, %0d input stall cycles",
               done_results, error_results, stall_cycles);
      if (mismatches == 0)
         $display("ftp_reply_frame_recognizer_top verification clean");
      else
         $display("ftp_reply_frame_recognizer_top verification failed");
      $finish;
   end

endmodule
